/* rtl/running_mean_variance_stats_defines.svh */
// Assertion macros shared by the statistics block.
`ifndef RUNNING_MEAN_VARIANCE_STATS_DEFINES_SVH
`define RUNNING_MEAN_VARIANCE_STATS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMVS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("running_mean_variance_stats: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RMVS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("running_mean_variance_stats: next-cycle check failed");

`endif

/* rtl/rmvs_pkg.sv */
package rmvs_pkg;

  // Widths of the sample path and of the internal accumulators.
  localparam int COUNT_BITS = 40;
  localparam int SAMPLE_W   = 48;
  localparam int MEAN_GUARD = 16;
  localparam int ACC_W      = 64;
  localparam int PROD_W     = 2 * ACC_W;
  localparam int REM_W      = COUNT_BITS + 1;
  localparam int STEP_W     = $clog2(ACC_W);

  // Result field widths.
  localparam int OUT_COUNT_W = 40;
  localparam int OUT_STD_W   = 47;
  localparam int OUT_DATA_W  = OUT_COUNT_W + 3 * SAMPLE_W + OUT_STD_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
  localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;

  // Extreme sample values used as the reset of min and max.
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_DIV1,
    ST_MEAN,
    ST_DELTA2,
    ST_MUL,
    ST_ACC,
    ST_DIV2,
    ST_SQRT,
    ST_OUT
  } rmvs_state_e;

endpackage

/* rtl/running_mean_variance_stats.sv */
// A request is taken only while the sequencer is idle, so a new one waits
// until the last result has gone to the output; two bit-serial 64-step divisions
// by the count, a bit-serial 64-step multiply and a 32-step square root share
// one sequencer. The output register frees the input while a result waits.
// Reset (rst_ni low, asynchronous) clears the statistics to count 0, min to
// the most positive and max to the most negative sample, mean and m2 to 0.
`include "running_mean_variance_stats_defines.svh"

module running_mean_variance_stats (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rmvs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [47:0] sample
  input  logic                              s_axis_tuser,  // [0] restart
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [39:0] sample_count, [87:40] min_value, [135:88] max_value,
  // [183:136] mean_value, [230:184] std_dev, [231] zero
  output logic [rmvs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import rmvs_pkg::*;

  rmvs_state_e state_q, state_d;

  // Statistics.
  logic        [COUNT_BITS-1:0] count_q, count_d;
  logic signed [SAMPLE_W-1:0]   min_q, min_d;
  logic signed [SAMPLE_W-1:0]   max_q, max_d;
  logic        [ACC_W-1:0]      mean_q, mean_d;
  logic        [ACC_W-1:0]      m2_q, m2_d;

  // Working registers of the serial units.
  logic [ACC_W-1:0]      xs_q;
  logic                  neg_q;
  logic [ACC_W-1:0]      mag_q;
  logic [ACC_W-1:0]      work_q;
  logic [COUNT_BITS-1:0] rem_q;
  logic [PROD_W-1:0]     acc_q;
  logic [ACC_W-1:0]      sq_r_q;
  logic [ACC_W-1:0]      sq_bit_q;
  logic [STEP_W-1:0]     step_q;
  logic                  out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic in_accept;
  logic out_free;
  logic out_load;
  logic last_step;
  logic signed [SAMPLE_W-1:0] x_s;

  assign x_s       = $signed(s_axis_tdata[SAMPLE_W-1:0]);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign last_step = (step_q == {STEP_W{1'b1}});

  // Deviation of the shifted sample from the current mean, as sign and magnitude.
  logic             dev_neg;
  logic [ACC_W-1:0] dev_mag;
  always_comb begin
    dev_neg = $signed(xs_q) < $signed(mean_q);
    dev_mag = dev_neg ? (mean_q - xs_q) : (xs_q - mean_q);
  end

  // One restoring division step: the dividend shifts out of work_q, the
  // quotient bits shift in behind it.
  logic [REM_W-1:0]      div_trial;
  logic                  div_fits;
  logic [COUNT_BITS-1:0] div_rem;
  always_comb begin
    div_trial = {rem_q, work_q[ACC_W-1]};
    div_fits  = div_trial >= {1'b0, count_q};
    div_rem   = div_fits ? COUNT_BITS'(div_trial - {1'b0, count_q})
                         : div_trial[COUNT_BITS-1:0];
  end

  // One shift-and-add multiply step, multiplier bits taken from work_q.
  logic [ACC_W:0] mul_sum;
  always_comb begin
    mul_sum = {1'b0, acc_q[PROD_W-1:ACC_W]} + (work_q[0] ? {1'b0, mag_q} : '0);
  end

  // Product shifted down by twice the guard bits, then the saturating m2 sum.
  logic [ACC_W-1:0] term;
  logic [ACC_W:0]   m2_sum;
  logic [ACC_W-1:0] m2_new;
  always_comb begin
    term   = (|acc_q[PROD_W-1:PROD_W-32]) ? {ACC_W{1'b1}} : acc_q[PROD_W-33:32];
    m2_sum = {1'b0, m2_q} + {1'b0, term};
    m2_new = m2_sum[ACC_W] ? {ACC_W{1'b1}} : m2_sum[ACC_W-1:0];
  end

  // One digit-by-digit square root step.
  logic [ACC_W-1:0] sq_try;
  logic             sq_ge;
  always_comb begin
    sq_try = sq_r_q + sq_bit_q;
    sq_ge  = work_q >= sq_try;
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_accept) state_d = ST_DELTA;
      ST_DELTA:  state_d = ST_DIV1;
      ST_DIV1:   if (last_step) state_d = ST_MEAN;
      ST_MEAN:   state_d = ST_DELTA2;
      ST_DELTA2: state_d = ST_MUL;
      ST_MUL:    if (last_step) state_d = ST_ACC;
      ST_ACC:    state_d = ST_DIV2;
      ST_DIV2:   if (last_step) state_d = ST_SQRT;
      ST_SQRT:   if (sq_bit_q[0]) state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer.
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_OUT:  out_load      = out_free;
      default: begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
      end
    endcase
  end

  // Next values of the statistics.
  always_comb begin
    count_d = count_q;
    min_d   = min_q;
    max_d   = max_q;
    mean_d  = mean_q;
    m2_d    = m2_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser) begin
            // A restart counts this sample as the first one.
            count_d = COUNT_BITS'(1);
            min_d   = x_s;
            max_d   = x_s;
            mean_d  = '0;
            m2_d    = '0;
          end else begin
            count_d = (count_q == {COUNT_BITS{1'b1}}) ? count_q : count_q + 1'b1;
            min_d   = (x_s < min_q) ? x_s : min_q;
            max_d   = (max_q < x_s) ? x_s : max_q;
          end
        end
      end
      ST_MEAN: mean_d = neg_q ? (mean_q - work_q) : (mean_q + work_q);
      ST_ACC:  m2_d   = m2_new;
      default: ;
    endcase
  end

  // Control and statistics registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      min_q       <= SAMPLE_MAX;
      max_q       <= SAMPLE_MIN;
      mean_q      <= '0;
      m2_q        <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      min_q   <= min_d;
      max_q   <= max_d;
      mean_q  <= mean_d;
      m2_q    <= m2_d;
      if (state_q == ST_DIV1 || state_q == ST_MUL || state_q == ST_DIV2) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the divider, multiplier and square root.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) xs_q <= {x_s, {MEAN_GUARD{1'b0}}};
      end
      ST_DELTA: begin
        neg_q  <= dev_neg;
        mag_q  <= dev_mag;
        work_q <= dev_mag;
        rem_q  <= '0;
      end
      ST_DIV1, ST_DIV2: begin
        work_q <= {work_q[ACC_W-2:0], div_fits};
        rem_q  <= div_rem;
        if (state_q == ST_DIV2 && last_step) begin
          sq_r_q   <= '0;
          sq_bit_q <= {2'b01, {(ACC_W-2){1'b0}}};
        end
      end
      ST_DELTA2: begin
        work_q <= dev_mag;
        acc_q  <= '0;
      end
      ST_MUL: begin
        acc_q  <= {mul_sum, acc_q[ACC_W-1:1]};
        work_q <= {1'b0, work_q[ACC_W-1:1]};
      end
      ST_ACC: begin
        work_q <= m2_new;
        rem_q  <= '0;
      end
      ST_SQRT: begin
        if (sq_ge) begin
          work_q <= work_q - sq_try;
          sq_r_q <= {1'b0, sq_r_q[ACC_W-1:1]} + sq_bit_q;
        end else begin
          sq_r_q <= {1'b0, sq_r_q[ACC_W-1:1]};
        end
        sq_bit_q <= {2'b00, sq_bit_q[ACC_W-1:2]};
      end
      default: ;
    endcase
  end

  // Result register.
  logic [ACC_W-1:0] count_wide;
  assign count_wide = ACC_W'(count_q);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= OUT_TDATA_W'({sq_r_q[OUT_STD_W-1:0],
                                  mean_q[MEAN_GUARD+SAMPLE_W-1:MEAN_GUARD],
                                  max_q, min_q, count_wide[OUT_COUNT_W-1:0]});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // An accepted request always starts the deviation step.
  `RMVS_ASSERT_NXT(a_accept_starts, clk_i, rst_ni, in_accept, state_q == ST_DELTA)
  // The count is never zero while a sample is being worked on.
  `RMVS_ASSERT_IMP(a_count_nonzero, clk_i, rst_ni, state_q != ST_IDLE, count_q != '0)
  // The division remainder always stays below the divisor.
  `RMVS_ASSERT_IMP(a_rem_bound, clk_i, rst_ni, state_q == ST_DIV1 || state_q == ST_DIV2, rem_q < count_q)
  // The square root walks a single bit down the word.
  `RMVS_ASSERT_IMP(a_sqrt_onehot, clk_i, rst_ni, state_q == ST_SQRT, $onehot(sq_bit_q))

endmodule
